FILE: hdl/sra_pkg.sv
// ----------------------------------------------------------------------------
// Shelf rectangle allocator package
// Shared widths, codes, command and status bundles, and the side doubling
// helper used by the grow unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  localparam int DIM_W     = 13;
  localparam int EXT_W     = 14;
  localparam int PAD_W     = 8;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [EXT_W-1:0] MAX_DIM   = 14'd4096;
  localparam logic [DIM_W-1:0] ATLAS_RST = 13'd512;
  localparam logic [PAD_W-1:0] PAD_RST   = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_FIT,
    S_GROW_INIT,
    S_GROW_STEP,
    S_GROW_END,
    S_PLACE_X,
    S_PLACE_Y,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOFIT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PASS_FIRST,
    PASS_RETRY,
    PASS_FINAL
  } pass_e;

  typedef struct packed {
    logic    load_req;
    logic    prep;
    logic    grow_init;
    logic    grow_step;
    logic    grow_apply;
    logic    evict;
    logic    place_x;
    logic    place_y;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic fits;
    logic grow_more;
    logic grow_ok;
    logic place_ok;
  } sts_t;

  // Doubles one atlas side, capped at the largest side.
  function automatic logic [DIM_W-1:0] dbl_dim(logic [DIM_W-1:0] n);
    logic [EXT_W-1:0] d;
    d = {n, 1'b0};
    if (d > MAX_DIM) begin
      dbl_dim = MAX_DIM[DIM_W-1:0];
    end else begin
      dbl_dim = d[DIM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sra_ctrl.sv
// ----------------------------------------------------------------------------
// Shelf rectangle allocator controller
// Sequences one request through size check, grow, shelf placement, evict
// and result hand-off, and owns the channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_ctrl
  import sra_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e  state_q, state_d;
  pass_e   pass_q, pass_d;
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;
  logic    slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    pass_d   = pass_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
          pass_d  = PASS_FIRST;
        end
      end
      S_PREP: begin
        state_d = S_FIT;
      end
      S_FIT: begin
        if (sts_i.invalid) begin
          status_d = ST_INVALID;
          state_d  = S_DONE;
        end else if (sts_i.fits) begin
          state_d = S_PLACE_X;
        end else begin
          state_d = S_GROW_INIT;
        end
      end
      S_GROW_INIT: begin
        state_d = S_GROW_STEP;
      end
      S_GROW_STEP: begin
        if (!sts_i.grow_more) begin
          state_d = S_GROW_END;
        end
      end
      S_GROW_END: begin
        if (pass_q == PASS_FIRST) begin
          if (sts_i.grow_ok) begin
            state_d = S_PLACE_X;
          end else begin
            status_d = ST_NOFIT;
            state_d  = S_DONE;
          end
        end else begin
          pass_d  = PASS_FINAL;
          state_d = S_PLACE_X;
        end
      end
      S_PLACE_X: begin
        state_d = S_PLACE_Y;
      end
      S_PLACE_Y: begin
        if (sts_i.place_ok) begin
          status_d = ST_PLACED;
          state_d  = S_DONE;
        end else if (pass_q == PASS_FIRST) begin
          pass_d  = PASS_RETRY;
          state_d = S_GROW_INIT;
        end else begin
          status_d = ST_NOFIT;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = status_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_req = in_valid_i;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
      end
      S_GROW_INIT: begin
        cmd_o.grow_init = 1'b1;
      end
      S_GROW_STEP: begin
        cmd_o.grow_step = sts_i.grow_more;
      end
      S_GROW_END: begin
        cmd_o.grow_apply = sts_i.grow_ok;
        cmd_o.evict      = (pass_q != PASS_FIRST) && !sts_i.grow_ok;
      end
      S_PLACE_X: begin
        cmd_o.place_x = 1'b1;
      end
      S_PLACE_Y: begin
        cmd_o.place_y = 1'b1;
      end
      S_DONE: begin
        cmd_o.out_load = slot_free;
      end
      default: begin
        cmd_o.load_req = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= PASS_FIRST;
      status_q    <= ST_PLACED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PREP))
    else $error("accepted item did not start preparation");

  a_no_grow_and_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.grow_apply && cmd_o.evict))
    else $error("grow and evict in the same cycle");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an item not yet taken");

  a_final_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GROW_INIT) |-> (pass_q != PASS_FINAL))
    else $error("grow started after the final placement attempt");

  a_evict_then_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.evict |=> (state_q == S_PLACE_X) && (pass_q == PASS_FINAL))
    else $error("evict not followed by the final placement");
`endif

endmodule

`default_nettype wire

FILE: hdl/sra_datapath.sv
// ----------------------------------------------------------------------------
// Shelf rectangle allocator datapath
// Atlas size, shelf cursors, counters, the iterative grow unit, the
// placement tests and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_datapath
  import sra_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [DIM_W-1:0]       cfg_data_i,
  input  wire [DIM_W-1:0]       rect_width_i,
  input  wire [DIM_W-1:0]       rect_height_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic [1:0]            status_o,
  output logic [DIM_W-1:0]      place_x_o,
  output logic [DIM_W-1:0]      place_y_o,
  output logic                  grew_o,
  output logic                  evicted_o,
  output logic [DIM_W-1:0]      width_now_o,
  output logic [DIM_W-1:0]      height_now_o,
  output logic [CNT_W-1:0]      generation_now_o,
  output logic [CNT_W-1:0]      placed_total_o,
  output logic [CNT_W-1:0]      evict_total_o,
  output logic [CNT_W-1:0]      grow_total_o
);

  logic [DIM_W-1:0] aw_q, ah_q;
  logic [DIM_W-1:0] cx_q;
  logic [EXT_W-1:0] cy_q, sh_q;
  logic [PAD_W-1:0] pad_q;
  logic [CNT_W-1:0] gen_q, place_cnt_q, evict_cnt_q, grow_cnt_q;

  logic [DIM_W-1:0] w_q, h_q;
  logic [EXT_W-1:0] pw_q, ph_q;
  logic             invalid_q;
  logic [DIM_W-1:0] nw_q, nh_q;
  logic [DIM_W-1:0] px_q, py_q;
  logic             grew_q, evicted_q;

  logic             nw_lt_max, nh_lt_max, unchanged;
  logic [EXT_W:0]   x_end, y_end;
  logic             x_over;
  logic [EXT_W-1:0] pad2;
  logic [EXT_W-1:0] px_sum, py_sum;

  assign pad2      = {5'd0, pad_q, 1'b0};
  assign nw_lt_max = {1'b0, nw_q} < MAX_DIM;
  assign nh_lt_max = {1'b0, nh_q} < MAX_DIM;
  assign unchanged = (nw_q == aw_q) && (nh_q == ah_q);
  assign x_end     = {2'b0, cx_q} + {1'b0, pw_q};
  assign y_end     = {1'b0, cy_q} + {1'b0, ph_q};
  assign x_over    = x_end > {2'b0, aw_q};
  assign px_sum    = {1'b0, cx_q} + {6'd0, pad_q};
  assign py_sum    = cy_q + {6'd0, pad_q};

  always_comb begin
    sts_o.invalid   = invalid_q;
    sts_o.fits      = (aw_q != '0) && (ah_q != '0) &&
                      (pw_q <= {1'b0, aw_q}) && (ph_q <= {1'b0, ah_q});
    sts_o.grow_more = (({1'b0, nw_q} < pw_q) || ({1'b0, nh_q} < ph_q) || unchanged) &&
                      (nw_lt_max || nh_lt_max);
    sts_o.grow_ok   = !unchanged && (pw_q <= {1'b0, nw_q}) && (ph_q <= {1'b0, nh_q});
    sts_o.place_ok  = y_end <= {2'b0, ah_q};
  end

  // Packing state, atlas size and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q        <= ATLAS_RST;
      ah_q        <= ATLAS_RST;
      cx_q        <= '0;
      cy_q        <= '0;
      sh_q        <= '0;
      pad_q       <= PAD_RST;
      gen_q       <= '0;
      place_cnt_q <= '0;
      evict_cnt_q <= '0;
      grow_cnt_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_START_W) begin
        aw_q <= cfg_data_i;
        cx_q <= '0;
        cy_q <= '0;
        sh_q <= '0;
      end else if (cfg_index_i == CFG_START_H) begin
        ah_q <= cfg_data_i;
        cx_q <= '0;
        cy_q <= '0;
        sh_q <= '0;
      end else if (cfg_index_i == CFG_PAD) begin
        pad_q <= cfg_data_i[PAD_W-1:0];
      end
    end else begin
      if (cmd_i.grow_apply) begin
        aw_q       <= nw_q;
        ah_q       <= nh_q;
        cx_q       <= '0;
        cy_q       <= '0;
        sh_q       <= '0;
        grow_cnt_q <= grow_cnt_q + 1'b1;
        gen_q      <= gen_q + 1'b1;
      end
      if (cmd_i.evict) begin
        cx_q        <= '0;
        cy_q        <= '0;
        sh_q        <= '0;
        evict_cnt_q <= evict_cnt_q + 1'b1;
        gen_q       <= gen_q + 1'b1;
      end
      if (cmd_i.place_x && x_over) begin
        cx_q <= '0;
        cy_q <= cy_q + sh_q;
        sh_q <= '0;
      end
      if (cmd_i.place_y && sts_o.place_ok) begin
        cx_q        <= x_end[DIM_W-1:0];
        place_cnt_q <= place_cnt_q + 1'b1;
        if (ph_q > sh_q) begin
          sh_q <= ph_q;
        end
      end
    end
  end

  // Request, grow unit and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      w_q       <= rect_width_i;
      h_q       <= rect_height_i;
      grew_q    <= 1'b0;
      evicted_q <= 1'b0;
    end
    if (cmd_i.prep) begin
      pw_q      <= {1'b0, w_q} + pad2;
      ph_q      <= {1'b0, h_q} + pad2;
      invalid_q <= (w_q == '0) || (h_q == '0);
    end
    if (cmd_i.grow_init) begin
      nw_q <= (aw_q == '0) ? DIM_W'(1) : aw_q;
      nh_q <= (ah_q == '0) ? DIM_W'(1) : ah_q;
    end
    if (cmd_i.grow_step) begin
      if ((nw_q <= nh_q) && nw_lt_max) begin
        nw_q <= dbl_dim(nw_q);
      end else if (nh_lt_max) begin
        nh_q <= dbl_dim(nh_q);
      end else begin
        nw_q <= dbl_dim(nw_q);
      end
    end
    if (cmd_i.grow_apply) begin
      grew_q <= 1'b1;
    end
    if (cmd_i.evict) begin
      evicted_q <= 1'b1;
    end
    if (cmd_i.place_y && sts_o.place_ok) begin
      px_q <= px_sum[DIM_W-1:0];
      py_q <= py_sum[DIM_W-1:0];
    end
    if (cmd_i.out_load) begin
      status_o         <= cmd_i.out_status;
      place_x_o        <= (cmd_i.out_status == ST_PLACED) ? px_q : '0;
      place_y_o        <= (cmd_i.out_status == ST_PLACED) ? py_q : '0;
      grew_o           <= grew_q;
      evicted_o        <= evicted_q;
      width_now_o      <= aw_q;
      height_now_o     <= ah_q;
      generation_now_o <= gen_q;
      placed_total_o   <= place_cnt_q;
      evict_total_o    <= evict_cnt_q;
      grow_total_o     <= grow_cnt_q;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/shelf_rect_allocator_with_grow_unit.sv
// ----------------------------------------------------------------------------
// Shelf rectangle allocator with grow
// Places padded rectangles in a texture atlas by shelf next-fit packing,
// growing the atlas by side doubling or evicting all space when needed.
//
//   Channel  Signals                               Direction
//   in       in_valid_i, in_ready_o, rect_*_i      request item in
//   out      out_valid_o, out_ready_i, *_o         result item out
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i     register write in
//
// A request whose size is zero is returned as invalid after the size check.
// Each grow pass doubles one side per step, up to 24 side doublings. A request
// that fails its first placement runs a second grow pass, which grows or evicts.
// No new request is taken until the current result is loaded for hand-off.
// Reset loads a 512 by 512 atlas, padding 1, and clears all counters.
// A result waiting on out_ready_i does not block the next request; only
// its hand-off waits for the output register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_rect_allocator_with_grow_unit
  import sra_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [DIM_W-1:0]       cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire [DIM_W-1:0]       rect_width_i,
  input  wire [DIM_W-1:0]       rect_height_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [1:0]            status_o,
  output logic [DIM_W-1:0]      place_x_o,
  output logic [DIM_W-1:0]      place_y_o,
  output logic                  grew_o,
  output logic                  evicted_o,
  output logic [DIM_W-1:0]      width_now_o,
  output logic [DIM_W-1:0]      height_now_o,
  output logic [CNT_W-1:0]      generation_now_o,
  output logic [CNT_W-1:0]      placed_total_o,
  output logic [CNT_W-1:0]      evict_total_o,
  output logic [CNT_W-1:0]      grow_total_o
);

  cmd_t cmd;
  sts_t sts;

  sra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sra_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .rect_width_i     (rect_width_i),
    .rect_height_i    (rect_height_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .place_x_o        (place_x_o),
    .place_y_o        (place_y_o),
    .grew_o           (grew_o),
    .evicted_o        (evicted_o),
    .width_now_o      (width_now_o),
    .height_now_o     (height_now_o),
    .generation_now_o (generation_now_o),
    .placed_total_o   (placed_total_o),
    .evict_total_o    (evict_total_o),
    .grow_total_o     (grow_total_o)
  );

endmodule

`default_nettype wire

FILE: dv/shelf_rect_allocator_with_grow_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shelf rectangle allocator with grow testbench
// Sends rectangle requests through the valid/ready input with random gaps and
// accepts results with random stalls. A shelf packing predictor with its own
// atlas, cursors and counters works out each result, and every field of every
// result is checked in order. Directed requests cover zero sizes, field
// extremes, shelf wrap, grow, eviction, zero and oversized atlas sides, and
// padding extremes; random phases follow under several atlas settings.
// ----------------------------------------------------------------------------
module shelf_rect_allocator_with_grow_unit_tb
  import sra_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 80;

  typedef struct packed {
    status_e          status;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic             grew;
    logic             evicted;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [CNT_W-1:0] gen;
    logic [CNT_W-1:0] placed;
    logic [CNT_W-1:0] evicts;
    logic [CNT_W-1:0] grows;
  } alloc_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = CFG_START_W;
  logic [DIM_W-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic [DIM_W-1:0]     rect_width_i  = '0;
  logic [DIM_W-1:0]     rect_height_i = '0;
  logic                 out_ready_i   = 1'b1;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [1:0]           status_o;
  logic [DIM_W-1:0]     place_x_o;
  logic [DIM_W-1:0]     place_y_o;
  logic                 grew_o;
  logic                 evicted_o;
  logic [DIM_W-1:0]     width_now_o;
  logic [DIM_W-1:0]     height_now_o;
  logic [CNT_W-1:0]     generation_now_o;
  logic [CNT_W-1:0]     placed_total_o;
  logic [CNT_W-1:0]     evict_total_o;
  logic [CNT_W-1:0]     grow_total_o;

  logic [31:0] atl_w      = 32'd512;
  logic [31:0] atl_h      = 32'd512;
  logic [31:0] pad_px     = 32'd1;
  logic [31:0] row_x      = '0;
  logic [31:0] row_y      = '0;
  logic [31:0] row_h      = '0;
  logic [31:0] gen_ctr    = '0;
  logic [31:0] placed_ctr = '0;
  logic [31:0] evict_ctr  = '0;
  logic [31:0] grow_ctr   = '0;

  alloc_result_t expected_allocs[$];
  int unsigned   idle_max     = 6;
  int unsigned   ready_wait   = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   result_count = 0;
  int unsigned   fail_count   = 0;

  always #4 clk_i = ~clk_i;

  shelf_rect_allocator_with_grow_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rect_width_i     (rect_width_i),
    .rect_height_i    (rect_height_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .place_x_o        (place_x_o),
    .place_y_o        (place_y_o),
    .grew_o           (grew_o),
    .evicted_o        (evicted_o),
    .width_now_o      (width_now_o),
    .height_now_o     (height_now_o),
    .generation_now_o (generation_now_o),
    .placed_total_o   (placed_total_o),
    .evict_total_o    (evict_total_o),
    .grow_total_o     (grow_total_o)
  );

  function automatic void clear_rows();
    row_x = '0;
    row_y = '0;
    row_h = '0;
  endfunction

  function automatic logic room_for(input logic [31:0] pw, input logic [31:0] ph);
    return atl_w > 0 && atl_h > 0 && pw <= atl_w && ph <= atl_h;
  endfunction

  function automatic logic shelf_fit(input logic [31:0] pw, input logic [31:0] ph,
                                     output logic [31:0] px, output logic [31:0] py);
    px = '0;
    py = '0;
    if (row_x + pw > atl_w) begin
      row_x = '0;
      row_y = row_y + row_h;
      row_h = '0;
    end
    if (row_y + ph > atl_h) begin
      return 1'b0;
    end
    px = row_x + pad_px;
    py = row_y + pad_px;
    row_x = row_x + pw;
    if (ph > row_h) begin
      row_h = ph;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] side_x2(input logic [31:0] n);
    logic [31:0] d;
    d = n * 2;
    return (d > 32'(MAX_DIM)) ? 32'(MAX_DIM) : d;
  endfunction

  function automatic logic grow_to(input logic [31:0] pw, input logic [31:0] ph);
    logic [31:0] nw;
    logic [31:0] nh;
    nw = (atl_w > 0) ? atl_w : 32'd1;
    nh = (atl_h > 0) ? atl_h : 32'd1;
    while ((nw < pw || nh < ph || (nw == atl_w && nh == atl_h)) &&
           (nw < 32'(MAX_DIM) || nh < 32'(MAX_DIM))) begin
      if (nw <= nh && nw < 32'(MAX_DIM)) begin
        nw = side_x2(nw);
      end else if (nh < 32'(MAX_DIM)) begin
        nh = side_x2(nh);
      end else begin
        nw = side_x2(nw);
      end
    end
    if (nw == atl_w && nh == atl_h) begin
      return 1'b0;
    end
    if (pw > nw || ph > nh) begin
      return 1'b0;
    end
    atl_w = nw;
    atl_h = nh;
    clear_rows();
    grow_ctr = grow_ctr + 1;
    gen_ctr  = gen_ctr + 1;
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_alloc(input logic [DIM_W-1:0] rw,
                                                  input logic [DIM_W-1:0] rh);
    alloc_result_t r;
    logic [31:0]   pw;
    logic [31:0]   ph;
    logic [31:0]   px;
    logic [31:0]   py;
    logic          ok;
    r = '0;
    r.status = ST_PLACED;
    px = '0;
    py = '0;
    if (rw == 0 || rh == 0) begin
      r.status = ST_INVALID;
    end else begin
      pw = 32'(rw) + 2 * pad_px;
      ph = 32'(rh) + 2 * pad_px;
      ok = 1'b1;
      if (!room_for(pw, ph)) begin
        if (grow_to(pw, ph)) begin
          r.grew = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      if (ok && !shelf_fit(pw, ph, px, py)) begin
        if (grow_to(pw, ph)) begin
          r.grew = 1'b1;
        end else begin
          clear_rows();
          evict_ctr = evict_ctr + 1;
          gen_ctr   = gen_ctr + 1;
          r.evicted = 1'b1;
        end
        if (!shelf_fit(pw, ph, px, py)) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        placed_ctr = placed_ctr + 1;
      end else begin
        r.status = ST_NOFIT;
        px = '0;
        py = '0;
      end
    end
    r.x      = px[DIM_W-1:0];
    r.y      = py[DIM_W-1:0];
    r.w      = atl_w[DIM_W-1:0];
    r.h      = atl_h[DIM_W-1:0];
    r.gen    = gen_ctr;
    r.placed = placed_ctr;
    r.evicts = evict_ctr;
    r.grows  = grow_ctr;
    return r;
  endfunction

  function automatic string field_diff(input string name, input logic [31:0] got,
                                       input logic [31:0] want);
    if (got !== want) begin
      return $sformatf(" %s exp %0d got %0d", name, want, got);
    end
    return "";
  endfunction

  task automatic record_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("result %0d:%s", result_count, msg);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    string         diff;
    int unsigned   stall;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_allocs.size() == 0) begin
        record_failure(" result arrived with no request pending");
      end else begin
        want = expected_allocs.pop_front();
        diff = {field_diff("status", 32'(status_o), 32'(want.status)),
                field_diff("place_x", 32'(place_x_o), 32'(want.x)),
                field_diff("place_y", 32'(place_y_o), 32'(want.y)),
                field_diff("grew", 32'(grew_o), 32'(want.grew)),
                field_diff("evicted", 32'(evicted_o), 32'(want.evicted)),
                field_diff("width_now", 32'(width_now_o), 32'(want.w)),
                field_diff("height_now", 32'(height_now_o), 32'(want.h)),
                field_diff("generation_now", generation_now_o, want.gen),
                field_diff("placed_total", placed_total_o, want.placed),
                field_diff("evict_total", evict_total_o, want.evicts),
                field_diff("grow_total", grow_total_o, want.grows)};
        if (diff != "") begin
          record_failure(diff);
        end
      end
      result_count++;
      stall = $urandom_range(idle_max, 0);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        ready_wait  <= stall;
      end
    end else if (!out_ready_i) begin
      if (ready_wait <= 1) begin
        out_ready_i <= 1'b1;
      end else begin
        ready_wait <= ready_wait - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_rect(input logic [DIM_W-1:0] rw, input logic [DIM_W-1:0] rh);
    int unsigned gap;
    gap = $urandom_range(idle_max, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rect_width_i  <= rw;
    rect_height_i <= rh;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_allocs.insert(expected_allocs.size(), predict_alloc(rw, rh));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_START_W: begin
        atl_w = 32'(val);
        clear_rows();
      end
      CFG_START_H: begin
        atl_h = 32'(val);
        clear_rows();
      end
      CFG_PAD: begin
        pad_px = 32'(val[PAD_W-1:0]);
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_atlas(input int unsigned w, input int unsigned h, input int unsigned pad);
    settle();
    write_reg(CFG_START_W, DIM_W'(w));
    write_reg(CFG_START_H, DIM_W'(h));
    write_reg(CFG_PAD, DIM_W'(pad));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DIM_W-1:0] rand_side();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 4) begin
      return '0;
    end else if (pick < 70) begin
      return DIM_W'($urandom_range(48, 1));
    end else if (pick < 85) begin
      return DIM_W'($urandom_range(400, 1));
    end else if (pick < 95) begin
      return DIM_W'($urandom_range(4096, 1));
    end
    return DIM_W'($urandom_range(8191, 0));
  endfunction

  task automatic test_zero_size();
    set_atlas(512, 512, 1);
    send_rect(13'd0, 13'd5);
    send_rect(13'd7, 13'd0);
    send_rect(13'd0, 13'd0);
  endtask

  task automatic test_size_extremes();
    send_rect(13'd1, 13'd1);
    send_rect(13'd8191, 13'd8191);
    send_rect(13'd8191, 13'd1);
    send_rect(13'd1, 13'd8191);
  endtask

  task automatic test_shelf_wrap_and_grow();
    set_atlas(512, 512, 1);
    send_rect(13'd500, 13'd100);
    send_rect(13'd300, 13'd200);
    send_rect(13'd510, 13'd300);
    send_rect(13'd4000, 13'd10);
  endtask

  task automatic test_evict();
    set_atlas(4096, 4096, 0);
    send_rect(13'd4096, 13'd4096);
    send_rect(13'd1, 13'd1);
    send_rect(13'd4096, 13'd4096);
  endtask

  task automatic test_zero_atlas_side();
    set_atlas(0, 0, 1);
    send_rect(13'd4, 13'd4);
    set_atlas(0, 512, 0);
    send_rect(13'd3, 13'd3);
  endtask

  task automatic test_oversized_atlas();
    set_atlas(8191, 100, 0);
    send_rect(13'd10, 13'd200);
    send_rect(13'd8191, 13'd5);
  endtask

  task automatic test_pad_extremes();
    set_atlas(512, 512, 255);
    send_rect(13'd1, 13'd1);
    send_rect(13'd2, 13'd2);
    set_atlas(64, 64, 0);
    send_rect(13'd64, 13'd64);
    send_rect(13'd64, 13'd64);
  endtask

  task automatic run_random_phase(input int unsigned w, input int unsigned h,
                                  input int unsigned pad, input int unsigned gaps,
                                  input int unsigned count);
    set_atlas(w, h, pad);
    idle_max = gaps;
    repeat (count) send_rect(rand_side(), rand_side());
  endtask

  task automatic test_random_mix();
    run_random_phase(512, 512, 1, 6, 100);
    run_random_phase(64, 64, 0, 0, 100);
    run_random_phase(0, 0, 3, 6, 100);
    run_random_phase(4096, 4096, 0, 3, 100);
    run_random_phase(8191, 8191, 255, 6, 100);
    run_random_phase(100, 37, 2, 0, 100);
    run_random_phase(1, 1, 1, 6, 100);
    run_random_phase(2048, 4096, 17, 2, 100);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_size();
    test_size_extremes();
    test_shelf_wrap_and_grow();
    test_evict();
    test_zero_atlas_side();
    test_oversized_atlas();
    test_pad_extremes();
    test_random_mix();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_allocs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: shelf_rect_allocator_with_grow_unit.f
hdl/sra_pkg.sv
hdl/sra_ctrl.sv
hdl/sra_datapath.sv
hdl/shelf_rect_allocator_with_grow_unit.sv
dv/shelf_rect_allocator_with_grow_unit_tb.sv
